// ===== design/hall_period_average_tachometer_top_assert.svh =====
// Assertion macros shared by the tachometer top level.
`ifndef HALL_PERIOD_AVERAGE_TACHOMETER_TOP_ASSERT_SVH
`define HALL_PERIOD_AVERAGE_TACHOMETER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checks a consequence in the same cycle as its antecedent.
`define HTACH_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tachometer check failed");
// Checks a consequence in the cycle after its antecedent.
`define HTACH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tachometer check failed");
`else
`define HTACH_ASSERT_SAME(lbl, ante, cons)
`define HTACH_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== design/htach_pkg.sv =====
// Types and constants of the hall period tachometer.
package htach_pkg;

  localparam int PERIOD_W = 32;
  localparam int SUM_W    = 36;
  localparam int RPM_W    = 16;
  // Divider remainder and divisor width: twice the mean needs 33 bits.
  localparam int REM_W    = 33;

  // The mean is the top bits of the sum times a 40-bit reciprocal, taken in 8-bit slices.
  localparam int RECIP_W  = 40;
  localparam int CHUNK_W  = 8;
  localparam int MAC_W    = SUM_W + CHUNK_W;

  localparam int MEAN_STEPS = RECIP_W / CHUNK_W;
  localparam int RPM_STEPS  = 16;
  localparam int CNT_W      = 5;

  // Twice 1250000, so that round half up becomes floor((2N + m) / 2m).
  localparam logic [REM_W-1:0] RPM_NUM2 = 33'd2500000;
  localparam logic [RPM_W-1:0] RPM_MAX  = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN_LOAD,
    ST_MEAN_RUN,
    ST_RPM_LOAD,
    ST_RPM_RUN,
    ST_FINISH
  } htach_state_t;

  typedef struct packed {
    logic win_shift;
    logic mean_load;
    logic mean_step;
    logic rpm_load;
    logic div_step;
    logic out_load;
  } htach_cmd_t;

  typedef struct packed {
    logic rpm_sat;
  } htach_sts_t;

endpackage

// ===== design/htach_in_if.sv =====
// Input channel: one measured hall period per beat.
interface htach_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] period_us;

  modport source (output valid, output period_us, input ready);
  modport sink (input valid, input period_us, output ready);
endinterface

// ===== design/htach_out_if.sv =====
// Result channel: speed, mean period and zero flag per beat.
interface htach_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] speed_rpm;
  logic [31:0] mean_period_us;
  logic        zero_period;

  modport source (output valid, output speed_rpm, output mean_period_us,
                  output zero_period, input ready);
  modport sink (input valid, input speed_rpm, input mean_period_us,
                input zero_period, output ready);
endinterface

// ===== design/htach_dp.sv =====
// Datapath: period window, running sum, reciprocal mean, restoring rpm divider, result register.
module htach_dp #(
  parameter int WINDOW_LEN = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [31:0]                in_period_us,
  input  htach_pkg::htach_cmd_t      cmd,
  output htach_pkg::htach_sts_t      sts,
  output logic [15:0]                out_speed_rpm,
  output logic [31:0]                out_mean_period_us,
  output logic                       out_zero_period
);
  import htach_pkg::*;

  // The reciprocal of the window length scaled by 2^40 and rounded up. For a sum
  // below 2^36 and a window of at most 16 entries its error never reaches the floor.
  localparam logic [RECIP_W-1:0] MEAN_RECIP =
    RECIP_W'(((64'd1 << RECIP_W) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));

  logic [PERIOD_W-1:0] win_r [WINDOW_LEN];
  logic [SUM_W-1:0]    sum_r;
  logic [SUM_W-1:0]    acc_r, acc_nxt;
  logic [RECIP_W-1:0]  recip_r, recip_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [PERIOD_W-1:0] dq_r, dq_nxt;
  logic [REM_W-1:0]    dv_r, dv_nxt;
  logic [PERIOD_W-1:0] mean_r;
  logic                sat_r;
  logic [RPM_W-1:0]    speed_r;
  logic [PERIOD_W-1:0] mean_out_r;
  logic                zero_r;

  logic [MAC_W-1:0]    prod;
  logic [MAC_W-1:0]    mac;
  logic [PERIOD_W-1:0] mean;
  logic [REM_W:0]      shifted;
  logic [REM_W:0]      trial;
  logic [REM_W-1:0]    num;
  logic [REM_W-1:0]    dbl;
  logic                sat;

  // Window and running sum. The window resets to zero, so the sum does too.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_r[i] <= '0;
      end
      sum_r <= '0;
    end else if (cmd.win_shift) begin
      for (int i = 0; i < WINDOW_LEN - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[WINDOW_LEN-1] <= in_period_us;
      sum_r <= sum_r - {4'b0, win_r[0]} + {4'b0, in_period_us};
    end
  end

  // Sum times one 8-bit reciprocal slice per cycle, lowest slice first; the low
  // byte drops off each time, so the last step leaves the floor of the mean.
  assign prod = MAC_W'(sum_r) * MAC_W'(recip_r[CHUNK_W-1:0]);
  assign mac  = MAC_W'(acc_r) + prod;
  assign mean = acc_r[PERIOD_W-1:0];

  // Round half up: quotient of (2N + m) by 2m, saturated once it needs 17 bits.
  assign num = RPM_NUM2 + {1'b0, mean};
  assign dbl = {mean, 1'b0};
  assign sat = {16'b0, num[REM_W-1:RPM_W]} >= dbl;
  assign sts.rpm_sat = sat;

  assign shifted = {rem_r, dq_r[PERIOD_W-1]};
  assign trial   = shifted - {1'b0, dv_r};

  always_comb begin
    acc_nxt   = acc_r;
    recip_nxt = recip_r;
    if (cmd.mean_load) begin
      acc_nxt   = '0;
      recip_nxt = MEAN_RECIP;
    end else if (cmd.mean_step) begin
      acc_nxt   = mac[MAC_W-1:CHUNK_W];
      recip_nxt = recip_r >> CHUNK_W;
    end
  end

  always_comb begin
    rem_nxt = rem_r;
    dq_nxt  = dq_r;
    dv_nxt  = dv_r;
    if (cmd.rpm_load) begin
      rem_nxt = {16'b0, num[REM_W-1:RPM_W]};
      dq_nxt  = {num[RPM_W-1:0], 16'b0};
      dv_nxt  = dbl;
    end else if (cmd.div_step) begin
      if (!trial[REM_W]) begin
        rem_nxt = trial[REM_W-1:0];
        dq_nxt  = {dq_r[PERIOD_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[REM_W-1:0];
        dq_nxt  = {dq_r[PERIOD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    recip_r <= recip_nxt;
    rem_r   <= rem_nxt;
    dq_r    <= dq_nxt;
    dv_r    <= dv_nxt;
    if (cmd.rpm_load) begin
      mean_r <= mean;
      sat_r  <= sat;
    end
    if (cmd.out_load) begin
      speed_r    <= sat_r ? RPM_MAX : dq_r[RPM_W-1:0];
      mean_out_r <= mean_r;
      zero_r     <= (mean_r == '0);
    end
  end

  assign out_speed_rpm      = speed_r;
  assign out_mean_period_us = mean_out_r;
  assign out_zero_period    = zero_r;

endmodule

// ===== design/htach_ctrl.sv =====
// Controller: sequences window update, mean multiply, rpm division and output.
module htach_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output htach_pkg::htach_cmd_t cmd,
  input  htach_pkg::htach_sts_t sts
);
  import htach_pkg::*;

  htach_state_t     state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.win_shift = 1'b1;
          state_nxt     = ST_MEAN_LOAD;
        end
      end
      ST_MEAN_LOAD: begin
        cmd.mean_load = 1'b1;
        cnt_nxt       = CNT_W'(MEAN_STEPS - 1);
        state_nxt     = ST_MEAN_RUN;
      end
      ST_MEAN_RUN: begin
        cmd.mean_step = 1'b1;
        cnt_nxt       = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_RPM_LOAD;
        end
      end
      ST_RPM_LOAD: begin
        cmd.rpm_load = 1'b1;
        cnt_nxt      = CNT_W'(RPM_STEPS - 1);
        // A saturated or zero mean needs no division.
        state_nxt    = sts.rpm_sat ? ST_FINISH : ST_RPM_RUN;
      end
      ST_RPM_RUN: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== design/hall_period_average_tachometer_top.sv =====
// Top level of the hall period moving-average tachometer.
//
//   channel  direction  beat carries
//   in_ch    sink       period_us
//   out_ch   source     speed_rpm, mean_period_us, zero_period
//
// From acceptance to a loaded result an item passes the mean load and the reciprocal
// multiply steps, the rpm divider load, the divider run unless the rpm saturates, and
// the result load. The next beat is taken in the idle state that follows.
// Reset is synchronous and clears the window, the sum and all control state.
// The result sits in an output register, so a new period is accepted while a
// result still waits; a result stalled past the next item's end holds the divider.
module hall_period_average_tachometer_top #(
  parameter int WINDOW_LEN = 10
) (
  input logic        clk,
  input logic        rst_n,
  htach_in_if.sink   in_ch,
  htach_out_if.source out_ch
);
  import htach_pkg::*;

  htach_cmd_t cmd;
  htach_sts_t sts;

  htach_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  htach_dp #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_period_us       (in_ch.period_us),
    .cmd                (cmd),
    .sts                (sts),
    .out_speed_rpm      (out_ch.speed_rpm),
    .out_mean_period_us (out_ch.mean_period_us),
    .out_zero_period    (out_ch.zero_period)
  );

`include "hall_period_average_tachometer_top_assert.svh"

  `HTACH_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
  `HTACH_ASSERT_SAME(a_zero_saturates, out_ch.valid && out_ch.zero_period, out_ch.speed_rpm == RPM_MAX)
  `HTACH_ASSERT_SAME(a_zero_flag_mean, out_ch.valid, out_ch.zero_period == (out_ch.mean_period_us == '0))
  `HTACH_ASSERT_SAME(a_one_load_at_a_time, 1'b1, $onehot0(cmd))

endmodule

// ===== tb/htach_speed_checker.sv =====
// Checker for the tachometer: predicts each reading from the period beats and compares it.
module htach_speed_checker #(
  parameter int WINDOW_LEN = 10
) (
  input  logic clk,
  input  logic rst_n,
  htach_in_if  in_ch,
  htach_out_if out_ch,
  output int   mismatch_count,
  output int   readings_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import htach_pkg::*;

  // Twice the rpm constant, so that rounding half up is a plain floor division.
  localparam longint unsigned SPEED_NUM_X2 = 64'd2500000;

  typedef struct packed {
    logic [RPM_W-1:0]    speed_rpm;
    logic [PERIOD_W-1:0] mean_period_us;
    logic                zero_period;
  } tach_reading_t;

  logic [PERIOD_W-1:0] period_hist [WINDOW_LEN];
  logic [SUM_W-1:0]    period_total;
  tach_reading_t       expected_readings [$];
  int                  fault_total = 0;

  // Shifts a new period into the window and returns the reading it leads to.
  function automatic tach_reading_t advance_window(input logic [PERIOD_W-1:0] newest);
    tach_reading_t  r;
    logic [PERIOD_W-1:0] oldest;
    logic [63:0]    mean64;
    logic [63:0]    quot;
    oldest = period_hist[0];
    for (int i = 0; i < WINDOW_LEN - 1; i++) period_hist[i] = period_hist[i + 1];
    period_hist[WINDOW_LEN - 1] = newest;
    period_total = period_total - SUM_W'(oldest) + SUM_W'(newest);
    mean64 = 64'(period_total) / 64'(WINDOW_LEN);
    r.mean_period_us = mean64[PERIOD_W-1:0];
    if (mean64 == 0) begin
      r.speed_rpm   = RPM_MAX;
      r.zero_period = 1'b1;
    end else begin
      quot = (SPEED_NUM_X2 + mean64) / (mean64 * 2);
      r.speed_rpm   = (quot > 64'(RPM_MAX)) ? RPM_MAX : quot[RPM_W-1:0];
      r.zero_period = 1'b0;
    end
    return r;
  endfunction

  task automatic compare_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      fault_total++;
    end
  endtask

  always @(posedge clk) begin
    tach_reading_t seen;
    tach_reading_t want;
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_LEN; i++) period_hist[i] = '0;
      period_total = '0;
      expected_readings.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen.speed_rpm      = out_ch.speed_rpm;
        seen.mean_period_us = out_ch.mean_period_us;
        seen.zero_period    = out_ch.zero_period;
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected reading, expected none, actual rpm %0d mean %0d zero %0b",
                   $time, seen.speed_rpm, seen.mean_period_us, seen.zero_period);
          fault_total++;
        end else begin
          want = expected_readings.pop_front();
          compare_field("speed_rpm", 32'(want.speed_rpm), 32'(seen.speed_rpm));
          compare_field("mean_period_us", want.mean_period_us, seen.mean_period_us);
          compare_field("zero_period", 32'(want.zero_period), 32'(seen.zero_period));
        end
      end
      if (in_ch.valid && in_ch.ready)
        expected_readings.push_back(advance_window(in_ch.period_us));
    end
    readings_pending <= expected_readings.size();
    mismatch_count   <= fault_total;
  end

endmodule

// ===== tb/tb_top.sv =====
// Top of the tachometer testbench: clock, reset, period stimulus, result backpressure, verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TACH_WINDOW  = 10;
  localparam int RANDOM_ITEMS = 1600;
  localparam int QUIET_TAIL   = 200;
  localparam int DRAIN_WAIT   = 80;
  localparam int CYCLE_LIMIT  = 1000000;

  logic clk;
  logic rst_n;
  int   mismatch_count;
  int   readings_pending;
  int   gap_pct   = 0;
  int   stall_pct = 0;

  htach_in_if  in_ch ();
  htach_out_if out_ch ();

  hall_period_average_tachometer_top #(
    .WINDOW_LEN(TACH_WINDOW)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  htach_speed_checker #(
    .WINDOW_LEN(TACH_WINDOW)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .mismatch_count  (mismatch_count),
    .readings_pending(readings_pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Sends one period beat, sometimes after a burst of idle cycles.
  task automatic push_period(input logic [31:0] period);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.period_us <= period;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Periods whose mean gives an exact half rpm: 32 times a power of five up to 2500000.
  function automatic logic [31:0] halfway_period();
    logic [31:0] m;
    m = 32;
    repeat ($urandom_range(0, 7)) m = m * 5;
    return m;
  endfunction

  function automatic logic [31:0] pick_period();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 10)      return $urandom_range(0, 40);
    else if (sel < 25) return $urandom();
    else if (sel < 30) return sel[0] ? 32'hFFFF_FFFF : 32'h0;
    else if (sel < 45) return halfway_period();
    else               return $urandom_range(20, 3000000);
  endfunction

  // Result side: ready drops in random bursts while stall_pct is nonzero.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] directed_periods [$];
    logic [31:0] steady;
    int          sent;
    int          next_phase;
    int          burst_len;
    bit          paused_once;
    int          pct_choices [3];

    pct_choices = '{0, 15, 50};
    // Zero mean with an empty and a nearly empty window, fast rotation that
    // saturates, an exact rpm, two half-way means, then a window of all ones.
    directed_periods = '{32'd0, 32'd9, 32'd11, 32'd170, 32'd10, 32'd120, 32'd1280};
    repeat (TACH_WINDOW) directed_periods.push_back(32'hFFFF_FFFF);
    directed_periods.push_back(32'h5555_5555);
    directed_periods.push_back(32'hAAAA_AAAA);
    directed_periods.push_back(32'h8000_0000);
    directed_periods.push_back(32'd1);

    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.period_us <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_periods[i]) push_period(directed_periods[i]);

    sent        = 0;
    next_phase  = 0;
    paused_once = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= RANDOM_ITEMS - QUIET_TAIL) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else if (sent >= next_phase) begin
        gap_pct    = pct_choices[$urandom_range(0, 2)];
        stall_pct  = pct_choices[$urandom_range(0, 2)];
        next_phase = next_phase + 200;
      end
      if (!paused_once && sent >= RANDOM_ITEMS / 2) begin
        // Hold the sender until every outstanding reading has come back.
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (readings_pending != 0) @(posedge clk);
        paused_once = 1'b1;
      end
      if ($urandom_range(0, 4) == 0) begin
        // A steady run fills the window so the mean lands on a chosen value.
        steady    = pick_period();
        burst_len = TACH_WINDOW + $urandom_range(0, 2);
        for (int k = 0; k < burst_len; k++) begin
          if ($urandom_range(0, 3) == 0 && steady < 32'hFFFF_FFF0)
            push_period(steady + $urandom_range(0, 3));
          else
            push_period(steady);
        end
        sent = sent + burst_len;
      end else begin
        push_period(pick_period());
        sent++;
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (readings_pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
